### src/dbcc_pkg.sv
// ----------------------------------------------------------------------------
// dbcc_pkg: shared definitions for the debounced button chord capture block
// Field widths, configuration codes and reset values, and the structs passed
// between the button lanes, the chord merge stage and the top level.
// ----------------------------------------------------------------------------
package dbcc_pkg;

    // Fixed field widths of the stream payloads.
    localparam int NOW_W      = 32;
    localparam int PIN_W      = 8;
    localparam int CHORD_W    = 8;
    localparam int IN_DATA_W  = 40;   // now_ms and pin_levels, whole bytes
    localparam int OUT_DATA_W = 8;    // chord_bits

    // Configuration port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_W-1:0] CHORD_WAIT_RST   = 16'd100;
    localparam logic             ACTIVE_LEVEL_RST = 1'b1;

    // Parameter defaults.
    localparam int BUTTONS_DEF   = 8;
    localparam int TIME_BITS_DEF = 32;

    typedef struct packed {
        logic [CFG_W-1:0] holdoff_ms;
        logic [CFG_W-1:0] chord_wait_ms;
        logic             active_level;
    } t_cfg;

    // What one lane reports for the poll at hand.
    typedef struct packed {
        logic sampled;     // button sampled and pressed
        logic new_press;   // button changed to pressed on this poll
    } t_lane_stat;

endpackage

### src/dbcc_lane.sv
// ----------------------------------------------------------------------------
// dbcc_lane: debounce lane for one button
// Holds the button's debounced state and last change time, and reports
// whether the button is sampled pressed and whether it newly went pressed.
// ----------------------------------------------------------------------------
module dbcc_lane #(
    parameter int TIME_BITS = dbcc_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_level,
    input  dbcc_pkg::t_cfg       i_cfg,
    output dbcc_pkg::t_lane_stat o_stat
);
    import dbcc_pkg::*;

    logic                 r_pressed, n_pressed;
    logic [TIME_BITS-1:0] r_change_time, n_change_time;

    logic                 pressed;
    logic [TIME_BITS-1:0] elapsed;
    logic                 eligible;
    logic                 change;

    // The subtraction wraps modulo 2^TIME_BITS, as the time base does.
    assign pressed  = (i_level == i_cfg.active_level);
    assign elapsed  = i_now - r_change_time;
    assign eligible = elapsed > TIME_BITS'(i_cfg.holdoff_ms);
    assign change   = eligible && (r_pressed != pressed);

    always_comb begin
        n_pressed     = r_pressed;
        n_change_time = r_change_time;
        if (i_step && change) begin
            n_pressed     = pressed;
            n_change_time = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed     <= 1'b0;
            r_change_time <= '0;
        end else begin
            r_pressed     <= n_pressed;
            r_change_time <= n_change_time;
        end
    end

    assign o_stat.sampled   = eligible && pressed;
    assign o_stat.new_press = change && pressed;

endmodule

### src/dbcc_merge.sv
// ----------------------------------------------------------------------------
// dbcc_merge: chord window merge stage
// Combines the lane reports into the chord accumulator, opens the window on
// the first press and emits the chord once the window time has elapsed.
// ----------------------------------------------------------------------------
module dbcc_merge #(
    parameter int BUTTONS   = dbcc_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = dbcc_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [BUTTONS-1:0]   i_sampled,
    input  logic [BUTTONS-1:0]   i_new_press,
    input  logic [dbcc_pkg::CFG_W-1:0] i_chord_wait_ms,
    output logic                 o_emit,
    output logic [BUTTONS-1:0]   o_chord
);
    import dbcc_pkg::*;

    logic                 r_open, n_open;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [BUTTONS-1:0]   r_accum, n_accum;

    logic                 any_press;
    logic                 open_now;
    logic [TIME_BITS-1:0] start_eff;
    logic [BUTTONS-1:0]   accum_new;
    logic [TIME_BITS-1:0] elapsed;

    assign any_press = |i_new_press;
    assign open_now  = r_open || any_press;

    // A window opened on this poll starts now with a cleared accumulator.
    assign start_eff = r_open ? r_start : (any_press ? i_now : r_start);
    assign accum_new = (r_open ? r_accum : (any_press ? '0 : r_accum)) | i_sampled;
    assign elapsed   = i_now - start_eff;
    assign o_emit    = open_now && (elapsed > TIME_BITS'(i_chord_wait_ms));
    assign o_chord   = o_emit ? accum_new : '0;

    always_comb begin
        n_open  = r_open;
        n_start = r_start;
        n_accum = r_accum;
        if (i_step && open_now) begin
            n_open  = !o_emit;
            n_start = o_emit ? i_now : start_eff;
            n_accum = accum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_start <= '0;
            r_accum <= '0;
        end else begin
            r_open  <= n_open;
            r_start <= n_start;
            r_accum <= n_accum;
        end
    end

endmodule

### src/debounced_button_chord_capture.sv
// ----------------------------------------------------------------------------
// debounced_button_chord_capture: debounced button poll with chord window
// Debounces a vector of button pins against a millisecond timestamp and
// collects presses that fall within a chord window into one chord result.
//
//   Channel    Direction  Transfer carries
//   s_axis     in         tdata: now_ms[31:0], pin_levels[39:32]
//   m_axis     out        tuser: chord_valid; tdata: chord_bits[7:0]
//   cfg        in         one register write per cycle, no read-back
//
// One poll is taken per cycle while s_axis is ready and yields one result; the
// per-button state and the chord window update in the cycle of the transfer, so
// polls follow back to back. Results are registered in the output stage.
// A two-entry output stage (output register plus skid) keeps s_axis ready
// while a single result waits; tready drops only once both entries are full.
// Reset is synchronous and active low and clears all button and chord state.
// ----------------------------------------------------------------------------
module debounced_button_chord_capture #(
    parameter int BUTTONS   = dbcc_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = dbcc_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input polls.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dbcc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // now_ms, pin_levels
    // Chord results.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [dbcc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // chord_bits
    output logic                              o_m_axis_tuser,  // chord_valid
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [dbcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbcc_pkg::CFG_W-1:0]        i_cfg_data
);
    import dbcc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:     n_cfg.holdoff_ms    = i_cfg_data;
                CFG_CHORD_WAIT:   n_cfg.chord_wait_ms = i_cfg_data;
                CFG_ACTIVE_LEVEL: n_cfg.active_level  = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff_ms    <= DEBOUNCE_RST;
            r_cfg.chord_wait_ms <= CHORD_WAIT_RST;
            r_cfg.active_level  <= ACTIVE_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking. Buttons beyond the pin field read a low level, and
    // the timestamp is cut or widened to the internal time base.
    // ------------------------------------------------------------------
    logic                 accept;
    logic [TIME_BITS-1:0] now;
    logic [BUTTONS-1:0]   levels;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign now    = TIME_BITS'(i_s_axis_tdata[NOW_W-1:0]);
    assign levels = BUTTONS'(i_s_axis_tdata[NOW_W +: PIN_W]);

    // ------------------------------------------------------------------
    // One debounce lane per button, all evaluated in parallel.
    // ------------------------------------------------------------------
    logic [BUTTONS-1:0] sampled;
    logic [BUTTONS-1:0] new_press;

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        t_lane_stat lane_stat;

        dbcc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (accept),
            .i_now   (now),
            .i_level (levels[g]),
            .i_cfg   (r_cfg),
            .o_stat  (lane_stat)
        );

        assign sampled[g]   = lane_stat.sampled;
        assign new_press[g] = lane_stat.new_press;
    end

    // ------------------------------------------------------------------
    // Chord merge.
    // ------------------------------------------------------------------
    logic               emit;
    logic [BUTTONS-1:0] chord;

    dbcc_merge #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (accept),
        .i_now           (now),
        .i_sampled       (sampled),
        .i_new_press     (new_press),
        .i_chord_wait_ms (r_cfg.chord_wait_ms),
        .o_emit          (emit),
        .o_chord         (chord)
    );

    // ------------------------------------------------------------------
    // Output register with skid entry. A result goes straight to the output
    // register when it is free, otherwise it parks in the skid entry.
    // ------------------------------------------------------------------
    logic               r_out_valid, n_out_valid;
    logic               r_out_flag, n_out_flag;
    logic [CHORD_W-1:0] r_out_bits, n_out_bits;
    logic               r_skid_valid, n_skid_valid;
    logic               r_skid_flag, n_skid_flag;
    logic [CHORD_W-1:0] r_skid_bits, n_skid_bits;

    logic               out_free;
    logic [CHORD_W-1:0] res_bits;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign res_bits = CHORD_W'(chord);

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_flag   = r_out_flag;
        n_out_bits   = r_out_bits;
        n_skid_valid = r_skid_valid;
        n_skid_flag  = r_skid_flag;
        n_skid_bits  = r_skid_bits;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_flag   = r_skid_flag;
                n_out_bits   = r_skid_bits;
                n_skid_valid = accept;
                n_skid_flag  = emit;
                n_skid_bits  = res_bits;
            end else begin
                n_out_valid  = accept;
                n_out_flag   = emit;
                n_out_bits   = res_bits;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_flag  = emit;
            n_skid_bits  = res_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_flag  <= n_out_flag;
        r_out_bits  <= n_out_bits;
        r_skid_flag <= n_skid_flag;
        r_skid_bits <= n_skid_bits;
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_bits;
    assign o_m_axis_tuser  = r_out_flag;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The skid entry only fills behind a held output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A transfer that meets a stalled output must park in the skid entry.
    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("result lost while output stalled");

    // A transfer into an idle output stage shows up at the output next cycle.
    a_free_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && out_free && !r_skid_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("result not presented after free transfer");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for debounced_button_chord_capture
// Walks a scripted list of polls covering reset state, the lockout and chord
// window boundaries, timestamp wrap and backwards steps, and then four
// randomized phases under different register settings. Every accepted poll is
// run through a behavioral model of the debouncer and the chord window, and
// each chord result transfer is compared against the oldest pending entry.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_POLLS   = 180;
    localparam int SCRIPT_ROWS   = 22;
    localparam int IDLE_PERCENT  = 34;

    // One chord result as the block presents it on m_axis.
    typedef struct packed {
        logic                         valid;
        logic [dbcc_pkg::CHORD_W-1:0] bits;
    } t_chord;

    // One scripted poll. Where typed is set, the expected chord is given in
    // the row itself instead of being taken from the model.
    typedef struct packed {
        logic [dbcc_pkg::NOW_W-1:0]   now;
        logic [dbcc_pkg::PIN_W-1:0]   pins;
        logic                         typed;
        logic                         want_valid;
        logic [dbcc_pkg::CHORD_W-1:0] want_bits;
    } t_poll_row;

    // Reset settings apply to the whole script: lockout 50 ms, window 100 ms,
    // pins active high.
    localparam t_poll_row SCRIPT [SCRIPT_ROWS] = '{
        // Right after reset every change time is zero, so nothing is sampled.
        '{32'd0,          8'h00, 1'b1, 1'b0, 8'h00},
        // All buttons pressed at once; the window opens on this poll.
        '{32'd51,         8'hFF, 1'b1, 1'b0, 8'h00},
        // Still inside the lockout of every button.
        '{32'd100,        8'h00, 1'b1, 1'b0, 8'h00},
        // Window expired: the full chord comes out.
        '{32'd152,        8'h00, 1'b1, 1'b1, 8'hFF},
        // Buttons joining a chord one after another, some still locked out.
        '{32'd203,        8'h01, 1'b0, 1'b0, 8'h00},
        '{32'd230,        8'h03, 1'b0, 1'b0, 8'h00},
        '{32'd255,        8'h83, 1'b0, 1'b0, 8'h00},
        '{32'd304,        8'h83, 1'b0, 1'b0, 8'h00},
        // Timestamp at the top of its range and wrapping through zero.
        '{32'hFFFF_FFF0,  8'h00, 1'b0, 1'b0, 8'h00},
        '{32'hFFFF_FFFF,  8'h10, 1'b0, 1'b0, 8'h00},
        '{32'd100,        8'h10, 1'b0, 1'b0, 8'h00},
        // Time stepping backwards reads as a very long elapsed time.
        '{32'd50,         8'h20, 1'b0, 1'b0, 8'h00},
        '{32'd40,         8'h20, 1'b0, 1'b0, 8'h00},
        // Lockout boundary: exactly 50 ms is still locked, 51 ms samples.
        '{32'd1000,       8'h00, 1'b0, 1'b0, 8'h00},
        '{32'd1050,       8'h20, 1'b0, 1'b0, 8'h00},
        '{32'd1051,       8'h20, 1'b0, 1'b0, 8'h00},
        // Window boundary: exactly 100 ms keeps it open, 101 ms emits.
        '{32'd1151,       8'h00, 1'b0, 1'b0, 8'h00},
        '{32'd1152,       8'h00, 1'b1, 1'b1, 8'h20},
        // Alternating pin patterns and a mid-range timestamp.
        '{32'd2000,       8'hAA, 1'b0, 1'b0, 8'h00},
        '{32'd2200,       8'h55, 1'b0, 1'b0, 8'h00},
        '{32'h8000_0000,  8'hFF, 1'b0, 1'b0, 8'h00},
        '{32'h8000_0000,  8'h00, 1'b0, 1'b0, 8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side of the block, all at known values from time zero.
    logic                              s_tvalid = 1'b0;
    logic [dbcc_pkg::IN_DATA_W-1:0]    s_tdata  = '0;  // now_ms[31:0], pin_levels[39:32]
    logic                              m_tready = 1'b0;
    logic                              cfg_we   = 1'b0;
    logic [dbcc_pkg::CFG_IDX_W-1:0]    cfg_idx  = dbcc_pkg::CFG_DEBOUNCE;
    logic [dbcc_pkg::CFG_W-1:0]        cfg_data = '0;

    logic                              o_s_axis_tready;
    logic                              o_m_axis_tvalid;
    logic [dbcc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;   // chord_bits
    logic                              o_m_axis_tuser;   // chord_valid

    // Model state: one lane per button plus the chord window.
    logic [dbcc_pkg::CFG_W-1:0]        lockout_ms;
    logic [dbcc_pkg::CFG_W-1:0]        window_ms;
    logic                              press_level;
    logic [dbcc_pkg::PIN_W-1:0]        btn_down;
    logic [dbcc_pkg::NOW_W-1:0]        btn_stamp [dbcc_pkg::PIN_W];
    logic                              win_open;
    logic [dbcc_pkg::NOW_W-1:0]        win_start;
    logic [dbcc_pkg::CHORD_W-1:0]      win_accum;

    t_chord chord_due [$];      // chords owed by the block, oldest first
    int     err_count   = 0;
    int     polls_sent  = 0;
    int     results_seen = 0;
    int     chords_seen = 0;
    int     cycles      = 0;
    bit     calm        = 1'b0; // set while neither side may idle

    debounced_button_chord_capture dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Run the debouncer and chord window over one poll and return the chord
    // result that poll must produce. All time differences wrap at 32 bits.
    function automatic t_chord predict_chord(input logic [dbcc_pkg::NOW_W-1:0] now,
                                             input logic [dbcc_pkg::PIN_W-1:0] pins);
        t_chord                       res;
        logic [dbcc_pkg::CHORD_W-1:0] hit;
        logic [dbcc_pkg::NOW_W-1:0]   gap;
        logic                         down;
        res = '0;
        hit = '0;
        for (int b = 0; b < dbcc_pkg::PIN_W; b++) begin
            down = (pins[b] == press_level);
            gap  = now - btn_stamp[b];
            if (gap > {16'd0, lockout_ms}) begin
                if (btn_down[b] != down) begin
                    btn_stamp[b] = now;
                    btn_down[b]  = down;
                    // The first press with no window open starts a new chord.
                    if (down && !win_open) begin
                        win_open  = 1'b1;
                        win_start = now;
                        win_accum = '0;
                    end
                end
                if (down)
                    hit[b] = 1'b1;
            end
        end
        if (win_open) begin
            win_accum = win_accum | hit;
            gap = now - win_start;
            if (gap > {16'd0, window_ms}) begin
                // The accumulator stays as it is until the next window opens.
                win_open  = 1'b0;
                win_start = now;
                res.valid = 1'b1;
                res.bits  = win_accum;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR at result %0d: %s is %0h, expected %0h",
                 results_seen, what, got, want);
        err_count++;
    endtask

    // Present one poll, with random idle cycles ahead of it, and hold it until
    // the transfer. The owed chord is queued at the edge of the transfer.
    task automatic send_poll(input logic [dbcc_pkg::NOW_W-1:0] now,
                             input logic [dbcc_pkg::PIN_W-1:0] pins,
                             input logic typed, input t_chord want);
        t_chord due;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pins, now};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        due = predict_chord(now, pins);
        chord_due.push_back(typed ? want : due);
        polls_sent++;
    endtask

    // Write all three registers on consecutive edges; only called while the
    // block holds no poll and owes no chord.
    task automatic load_settings(input logic [dbcc_pkg::CFG_W-1:0] db,
                                 input logic [dbcc_pkg::CFG_W-1:0] wt,
                                 input logic lvl);
        cfg_we   <= 1'b1;
        cfg_idx  <= dbcc_pkg::CFG_DEBOUNCE;
        cfg_data <= db;
        @(posedge i_clk);
        cfg_idx  <= dbcc_pkg::CFG_CHORD_WAIT;
        cfg_data <= wt;
        @(posedge i_clk);
        cfg_idx  <= dbcc_pkg::CFG_ACTIVE_LEVEL;
        cfg_data <= {15'd0, lvl};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        lockout_ms  = db;
        window_ms   = wt;
        press_level = lvl;
    endtask

    // Result side: random back-pressure, and a check of every transfer
    // against the oldest owed chord.
    always @(posedge i_clk) begin
        t_chord got;
        t_chord want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            if (o_m_axis_tvalid && m_tready) begin
                got.valid = o_m_axis_tuser;
                got.bits  = o_m_axis_tdata;
                if (got.valid)
                    chords_seen++;
                if (chord_due.size() == 0) begin
                    report_mismatch("result with no poll pending", 32'(got), 0);
                end else begin
                    want = chord_due.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch("chord_valid", 32'(got.valid), 32'(want.valid));
                    if (got.bits !== want.bits)
                        report_mismatch("chord_bits", 32'(got.bits), 32'(want.bits));
                end
                results_seen++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d chords pending",
                 cycles, chord_due.size());
        $display("Mismatches found");
        $finish;
    end

    // Main stimulus: reset, the scripted polls, then four random phases.
    initial begin
        logic [dbcc_pkg::NOW_W-1:0] clock_ms;
        logic [dbcc_pkg::NOW_W-1:0] step;
        logic [dbcc_pkg::PIN_W-1:0] levels;
        logic [dbcc_pkg::CFG_W-1:0] db;
        logic [dbcc_pkg::CFG_W-1:0] wt;
        logic                       lvl;
        int                         sel;
        int                         bit_ix;
        t_chord                     want;

        lockout_ms  = dbcc_pkg::DEBOUNCE_RST;
        window_ms   = dbcc_pkg::CHORD_WAIT_RST;
        press_level = dbcc_pkg::ACTIVE_LEVEL_RST;
        btn_down    = '0;
        foreach (btn_stamp[b])
            btn_stamp[b] = '0;
        win_open  = 1'b0;
        win_start = '0;
        win_accum = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            want.valid = SCRIPT[r].want_valid;
            want.bits  = SCRIPT[r].want_bits;
            send_poll(SCRIPT[r].now, SCRIPT[r].pins, SCRIPT[r].typed, want);
        end

        for (int p = 0; p < 4; p++) begin
            s_tvalid <= 1'b0;
            while (chord_due.size() != 0)
                @(posedge i_clk);
            // Settings per phase: all registers at their low end, all at
            // their high end, small random values, and full-range random.
            case (p)
                0: begin
                    db = 16'd0;      wt = 16'd0;      lvl = 1'b0;
                end
                1: begin
                    db = 16'hFFFF;   wt = 16'hFFFF;   lvl = 1'b1;
                end
                2: begin
                    db = 16'($urandom_range(1, 150));
                    wt = 16'($urandom_range(1, 400));
                    lvl = 1'($urandom);
                end
                default: begin
                    db = 16'($urandom);
                    wt = 16'($urandom);
                    lvl = 1'($urandom);
                end
            endcase
            load_settings(db, wt, lvl);
            // The first phase runs with no idle cycles on either side.
            calm     = (p == 0);
            clock_ms = $urandom;
            levels   = 8'($urandom);

            for (int n = 0; n < PHASE_POLLS; n++) begin
                // Mostly forward time steps scaled to the settings, landing
                // near the lockout and window edges; a few big jumps and a
                // few steps backwards.
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    step = $urandom_range(0, lockout_ms / 4 + 8);
                else if (sel < 70)
                    step = lockout_ms + $urandom_range(0, 2);
                else if (sel < 85)
                    step = window_ms + $urandom_range(0, 2);
                else if (sel < 95)
                    step = $urandom;
                else
                    step = 32'd0 - $urandom_range(1, 64);
                clock_ms = clock_ms + step;

                // Pins are held on half of the polls, with single-button flips, fresh
                // random patterns and the odd full inversion on the rest.
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    bit_ix = $urandom_range(0, dbcc_pkg::PIN_W - 1);
                    levels[bit_ix] = ~levels[bit_ix];
                end else if (sel < 45) begin
                    levels = 8'($urandom);
                end else if (sel < 50) begin
                    levels = ~levels;
                end
                send_poll(clock_ms, levels, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (chord_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d polls across the reset settings and four register phases;",
                 polls_sent);
        $display("checked %0d results, %0d of them completed chords.",
                 results_seen, chords_seen);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
